FILE: hw/rtl/ffsa_pkg.sv
`timescale 1ns / 1ps
package ffsa_pkg;

	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	localparam int HDR_W  = 8;
	localparam int RSZ_W  = 22;
	localparam int GRAIN  = 4;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_REALLOC = 2'd2;
	localparam logic [1:0] REQ_NOP     = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OOM     = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;

	localparam logic CFG_HDR   = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              free;
	} seg_t;

	typedef enum logic [4:0] {
		CMD_NOP, CMD_LOAD, CMD_RD_K, CMD_RD_K1, CMD_INC_K, CMD_TAKE, CMD_NOTFOUND,
		CMD_OOM, CMD_GROW, CMD_WB_USED, CMD_WB_KEEP, CMD_WB_CUR, CMD_SETK_TOP,
		CMD_UP_WR, CMD_SPLIT_INS, CMD_DN_WR, CMD_DN_END, CMD_FR_START, CMD_RD_NEXT,
		CMD_MERGE_PREV, CMD_ABSORB, CMD_TRIM, CMD_MOVE, CMD_SET_COPY
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_AL_RD, S_AL_CHK, S_GROW, S_SP_CHK, S_UP_RD, S_UP_WR,
		S_SP_INS, S_SP_WB, S_LK_RD, S_LK_CHK, S_RA_CHK, S_RA_NCHK, S_RA_AFT, S_MOVE,
		S_OLD_INIT, S_OLD_RD, S_OLD_CHK, S_FR_START, S_FR_PREV, S_FR_NEXT, S_FR_NCHK,
		S_FR_WB, S_DN_RD, S_DN_WR, S_DONE
	} state_t;

	typedef struct packed {
		logic is_nop;
		logic is_alloc;
		logic is_free_null;
		logic is_free;
		logic k_end;
		logic fit;
		logic hit;
		logic own;
		logic room;
		logic grow_ok;
		logic i_zero;
		logic has_next;
		logic rd_free;
		logic cur_ge;
		logic merge_ok;
		logic dn_more;
		logic up_more;
	} dp_status_t;

endpackage

FILE: hw/rtl/ffsa_datapath.sv
`timescale 1ns / 1ps
module ffsa_datapath #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffsa_pkg::cmd_t                cmd,
	output ffsa_pkg::dp_status_t          stat,
	input  logic [1:0]                    req_type,
	input  logic [ffsa_pkg::SIZE_W-1:0]   request_size,
	input  logic                          address_present,
	input  logic [ffsa_pkg::ADDR_W-1:0]   payload_address,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [ffsa_pkg::SIZE_W-1:0]   cfg_data,
	output logic [1:0]                    status,
	output logic                          result_present,
	output logic [ffsa_pkg::ADDR_W-1:0]   result_address,
	output logic [ffsa_pkg::SIZE_W-1:0]   granted_size,
	output logic                          copy_needed,
	output logic [ffsa_pkg::ADDR_W-1:0]   copy_from,
	output logic [ffsa_pkg::SIZE_W-1:0]   copy_length
);
	import ffsa_pkg::*;

	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [SIZE_W-1:0] AMASK = SIZE_W'((1 << ADDR_W) - 1);

	seg_t mem [MAX_SEGMENTS];
	seg_t rdata_q, cur_q, wd;
	logic we;
	logic [IDX_W-1:0] wa, ra, i_q;
	logic [CNT_W-1:0] cnt_q, k_q;
	logic [SIZE_W-1:0] top_q, lim_q, lim_eff, old_size_q;
	logic [HDR_W-1:0] hdr_q;
	logic [1:0] req_q;
	logic pres_q;
	logic [ADDR_W-1:0] paddr_q, old_start_q, old_pay_q, cur_pay, rd_pay;
	logic [RSZ_W-1:0] s_q, cur_rem;
	logic [SIZE_W+1:0] grow_sum, merge_sum;
	logic [CNT_W:0] k_inc, i_inc;

	assign cur_pay   = cur_q.start + ADDR_W'(hdr_q);
	assign rd_pay    = rdata_q.start + ADDR_W'(hdr_q);
	assign cur_rem   = RSZ_W'(cur_q.size) - s_q;
	assign grow_sum  = (SIZE_W+2)'(top_q) + (SIZE_W+2)'(hdr_q) + (SIZE_W+2)'(s_q);
	assign merge_sum = (SIZE_W+2)'(cur_q.size) + (SIZE_W+2)'(hdr_q)
		+ (SIZE_W+2)'(rdata_q.size);
	assign lim_eff   = (lim_q > AMASK) ? AMASK : lim_q;
	assign k_inc     = (CNT_W+1)'(k_q) + 1'b1;
	assign i_inc     = (CNT_W+1)'(i_q) + 1'b1;

	always_comb begin
		stat.is_nop       = (req_q == REQ_NOP);
		stat.is_alloc     = (req_q == REQ_ALLOC) || (req_q == REQ_REALLOC && !pres_q);
		stat.is_free_null = (req_q == REQ_FREE) && !pres_q;
		stat.is_free      = (req_q == REQ_FREE);
		stat.k_end        = (k_q >= cnt_q);
		stat.fit          = rdata_q.free && (RSZ_W'(rdata_q.size) >= s_q);
		stat.hit          = (rd_pay == paddr_q);
		stat.own          = (rdata_q.start == old_start_q) && !rdata_q.free;
		stat.room         = (cnt_q < CNT_W'(MAX_SEGMENTS))
			&& (cur_rem >= RSZ_W'(hdr_q) + RSZ_W'(GRAIN));
		stat.grow_ok      = (cnt_q < CNT_W'(MAX_SEGMENTS))
			&& (grow_sum <= (SIZE_W+2)'(lim_eff));
		stat.i_zero       = (i_q == '0);
		stat.has_next     = (i_inc < (CNT_W+1)'(cnt_q));
		stat.rd_free      = rdata_q.free;
		stat.cur_ge       = (RSZ_W'(cur_q.size) >= s_q);
		stat.merge_ok     = rdata_q.free && (merge_sum >= (SIZE_W+2)'(s_q));
		stat.dn_more      = (k_inc < (CNT_W+1)'(cnt_q));
		stat.up_more      = (k_q > CNT_W'(i_q));
	end

	// table port selection
	always_comb begin
		we = 1'b0;
		wa = i_q;
		ra = k_q[IDX_W-1:0];
		wd = cur_q;
		case (cmd)
			CMD_RD_K1:    ra = k_inc[IDX_W-1:0];
			CMD_FR_START: ra = i_q - 1'b1;
			CMD_RD_NEXT:  ra = i_q + 1'b1;
			CMD_UP_WR: begin
				we = 1'b1;
				wa = k_inc[IDX_W-1:0];
				wd = rdata_q;
			end
			CMD_DN_WR: begin
				we = 1'b1;
				wa = k_q[IDX_W-1:0];
				wd = rdata_q;
			end
			CMD_SPLIT_INS: begin
				we = 1'b1;
				wa = i_q + 1'b1;
				wd.start = cur_q.start + ADDR_W'(hdr_q) + ADDR_W'(s_q);
				wd.size  = cur_q.size - SIZE_W'(s_q) - SIZE_W'(hdr_q);
				wd.free  = 1'b1;
			end
			CMD_GROW: begin
				we = 1'b1;
				wa = cnt_q[IDX_W-1:0];
				wd.start = top_q[ADDR_W-1:0];
				wd.size  = s_q[SIZE_W-1:0];
				wd.free  = 1'b0;
			end
			CMD_WB_USED: begin
				we = 1'b1;
				wd.free = 1'b0;
			end
			CMD_WB_KEEP, CMD_WB_CUR: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			top_q <= '0;
			hdr_q <= HDR_W'(40);
			lim_q <= SIZE_W'(1048576);
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HDR) begin
					hdr_q <= cfg_data[HDR_W-1:0];
				end else begin
					lim_q <= cfg_data;
				end
			end
			case (cmd)
				CMD_GROW: begin
					cnt_q <= cnt_q + 1'b1;
					top_q <= grow_sum[SIZE_W-1:0];
				end
				CMD_SPLIT_INS: cnt_q <= cnt_q + 1'b1;
				CMD_DN_END:    cnt_q <= cnt_q - 1'b1;
				CMD_TRIM: begin
					cnt_q <= cnt_q - 1'b1;
					top_q <= SIZE_W'(cur_q.start);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				req_q          <= req_type;
				s_q            <= (RSZ_W'(request_size) + RSZ_W'(GRAIN - 1))
					& ~RSZ_W'(GRAIN - 1);
				pres_q         <= address_present;
				paddr_q        <= payload_address;
				k_q            <= '0;
				status         <= ST_OK;
				result_present <= 1'b0;
				result_address <= '0;
				granted_size   <= '0;
				copy_needed    <= 1'b0;
				copy_from      <= '0;
				copy_length    <= '0;
			end
			CMD_INC_K, CMD_DN_WR: k_q <= k_q + 1'b1;
			CMD_UP_WR:    k_q <= k_q - 1'b1;
			CMD_SETK_TOP: k_q <= cnt_q - 1'b1;
			CMD_TAKE: begin
				i_q   <= k_q[IDX_W-1:0];
				cur_q <= rdata_q;
			end
			CMD_NOTFOUND: status <= ST_BADADDR;
			CMD_OOM:      status <= ST_OOM;
			CMD_GROW: begin
				result_present <= 1'b1;
				result_address <= top_q[ADDR_W-1:0] + ADDR_W'(hdr_q);
				granted_size   <= s_q[SIZE_W-1:0];
			end
			CMD_WB_USED, CMD_WB_KEEP: begin
				if (cmd == CMD_WB_USED) begin
					cur_q.free <= 1'b0;
				end
				result_present <= 1'b1;
				result_address <= cur_pay;
				granted_size   <= cur_q.size;
			end
			CMD_SPLIT_INS: cur_q.size <= s_q[SIZE_W-1:0];
			CMD_FR_START:  cur_q.free <= 1'b1;
			CMD_MERGE_PREV: begin
				cur_q.start <= rdata_q.start;
				cur_q.size  <= merge_sum[SIZE_W-1:0];
				k_q         <= CNT_W'(i_q);
				i_q         <= i_q - 1'b1;
			end
			CMD_ABSORB: begin
				cur_q.size <= merge_sum[SIZE_W-1:0];
				k_q        <= i_inc[CNT_W-1:0];
			end
			CMD_MOVE: begin
				old_start_q <= cur_q.start;
				old_size_q  <= cur_q.size;
				old_pay_q   <= cur_pay;
				k_q         <= '0;
			end
			CMD_SET_COPY: begin
				copy_needed <= 1'b1;
				copy_from   <= old_pay_q;
				copy_length <= old_size_q;
				k_q         <= '0;
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/ffsa_ctrl.sv
`timescale 1ns / 1ps
module ffsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ffsa_pkg::dp_status_t stat,
	output ffsa_pkg::cmd_t       cmd,
	output logic                 busy,
	output logic                 done
);
	import ffsa_pkg::*;

	state_t state_q, state_d, dn_ret_q, dn_ret_d;
	logic alloc_q, alloc_d, mv_q, mv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dn_ret_q <= S_IDLE;
			alloc_q  <= 1'b0;
			mv_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			dn_ret_q <= dn_ret_d;
			alloc_q  <= alloc_d;
			mv_q     <= mv_d;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		dn_ret_d = dn_ret_q;
		alloc_d  = alloc_q;
		mv_d     = mv_q;
		case (state_q)
			S_IDLE: if (start) begin
				state_d = S_DECODE;
			end
			S_DECODE: begin
				alloc_d = stat.is_alloc;
				mv_d    = 1'b0;
				if (stat.is_nop || stat.is_free_null) begin
					state_d = S_DONE;
				end else if (stat.is_alloc) begin
					state_d = S_AL_RD;
				end else begin
					state_d = S_LK_RD;
				end
			end
			S_AL_RD:  state_d = stat.k_end ? S_GROW : S_AL_CHK;
			S_AL_CHK: state_d = stat.fit ? S_SP_CHK : S_AL_RD;
			S_GROW:   state_d = (stat.grow_ok && mv_q) ? S_OLD_INIT : S_DONE;
			S_SP_CHK: state_d = stat.room ? S_UP_RD : S_SP_WB;
			S_UP_RD:  state_d = stat.up_more ? S_UP_WR : S_SP_INS;
			S_UP_WR:  state_d = S_UP_RD;
			S_SP_INS: state_d = S_SP_WB;
			S_SP_WB:  state_d = mv_q ? S_OLD_INIT : S_DONE;
			S_LK_RD:  state_d = stat.k_end ? S_DONE : S_LK_CHK;
			S_LK_CHK: begin
				if (!stat.hit) begin
					state_d = S_LK_RD;
				end else if (stat.is_free) begin
					state_d = S_FR_START;
				end else begin
					state_d = S_RA_CHK;
				end
			end
			S_RA_CHK: begin
				if (stat.cur_ge) begin
					state_d = S_SP_CHK;
				end else if (stat.has_next) begin
					state_d = S_RA_NCHK;
				end else begin
					state_d = S_MOVE;
				end
			end
			S_RA_NCHK: begin
				if (stat.merge_ok) begin
					dn_ret_d = S_RA_AFT;
					state_d  = S_DN_RD;
				end else begin
					state_d = S_MOVE;
				end
			end
			S_RA_AFT: state_d = stat.cur_ge ? S_SP_CHK : S_SP_WB;
			S_MOVE: begin
				alloc_d = 1'b1;
				mv_d    = 1'b1;
				state_d = S_AL_RD;
			end
			S_OLD_INIT: state_d = S_OLD_RD;
			S_OLD_RD:   state_d = stat.k_end ? S_DONE : S_OLD_CHK;
			S_OLD_CHK:  state_d = stat.own ? S_FR_START : S_OLD_RD;
			S_FR_START: state_d = stat.i_zero ? S_FR_NEXT : S_FR_PREV;
			S_FR_PREV: begin
				if (stat.rd_free) begin
					dn_ret_d = S_FR_NEXT;
					state_d  = S_DN_RD;
				end else begin
					state_d = S_FR_NEXT;
				end
			end
			S_FR_NEXT: state_d = stat.has_next ? S_FR_NCHK : S_DONE;
			S_FR_NCHK: begin
				if (stat.rd_free) begin
					dn_ret_d = S_FR_WB;
					state_d  = S_DN_RD;
				end else begin
					state_d = S_FR_WB;
				end
			end
			S_FR_WB:  state_d = S_DONE;
			S_DN_RD:  state_d = stat.dn_more ? S_DN_WR : dn_ret_q;
			S_DN_WR:  state_d = S_DN_RD;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd  = CMD_NOP;
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
		case (state_q)
			S_IDLE:     if (start) begin
				cmd = CMD_LOAD;
			end
			S_AL_RD, S_LK_RD, S_OLD_RD: if (!stat.k_end) begin
				cmd = CMD_RD_K;
			end else if (state_q == S_LK_RD) begin
				cmd = CMD_NOTFOUND;
			end
			S_AL_CHK:   cmd = stat.fit ? CMD_TAKE : CMD_INC_K;
			S_LK_CHK:   cmd = stat.hit ? CMD_TAKE : CMD_INC_K;
			S_OLD_CHK:  cmd = stat.own ? CMD_TAKE : CMD_INC_K;
			S_GROW:     cmd = stat.grow_ok ? CMD_GROW : CMD_OOM;
			S_SP_CHK:   if (stat.room) begin
				cmd = CMD_SETK_TOP;
			end
			S_UP_RD:    if (stat.up_more) begin
				cmd = CMD_RD_K;
			end
			S_UP_WR:    cmd = CMD_UP_WR;
			S_SP_INS:   cmd = CMD_SPLIT_INS;
			S_SP_WB:    cmd = alloc_q ? CMD_WB_USED : CMD_WB_KEEP;
			S_RA_CHK:   if (!stat.cur_ge && stat.has_next) begin
				cmd = CMD_RD_NEXT;
			end
			S_RA_NCHK, S_FR_NCHK: if (stat.rd_free && (state_q == S_FR_NCHK || stat.merge_ok))
				begin
				cmd = CMD_ABSORB;
			end
			S_MOVE:     cmd = CMD_MOVE;
			S_OLD_INIT: cmd = CMD_SET_COPY;
			S_FR_START: cmd = CMD_FR_START;
			S_FR_PREV:  if (stat.rd_free) begin
				cmd = CMD_MERGE_PREV;
			end
			S_FR_NEXT:  cmd = stat.has_next ? CMD_RD_NEXT : CMD_TRIM;
			S_FR_WB:    cmd = CMD_WB_CUR;
			S_DN_RD:    cmd = stat.dn_more ? CMD_RD_K1 : CMD_DN_END;
			S_DN_WR:    cmd = CMD_DN_WR;
			default:    cmd = CMD_NOP;
		endcase
	end

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block not idle after result");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");
`endif

endmodule

FILE: hw/rtl/first_fit_segment_allocator.sv
`timescale 1ns / 1ps
// first-fit heap segment allocator with split, coalesce and top trimming
//
// request channel: a request (alloc, free, realloc) is taken on a clock edge
// where start is high and busy is low; busy stays high until the result
// the result channel: done pulses for exactly one cycle with status and all
// result fields valid in that cycle; the receiver cannot hold it off, so the
// result is a transfer on that edge regardless
// config channel: cfg_ready is always high; index 0 writes header_bytes,
// index 1 writes heap_limit; write only while the block is idle
// no-op and free of null go straight to the result; every other request
// visits table entries one by one in each search, and moves entries one by
// one when the table is opened for a split or closed after a merge; the
// worst case is a realloc that moves and frees
// one request at a time; the dual-port segment table sets the pace
// reset: empty heap, segment count and heap top zero, header 40 bytes,
// limit 1 MiB; table contents are only read below the segment count
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [ffsa_pkg::SIZE_W-1:0]   request_size,
	input  logic                          address_present,
	input  logic [ffsa_pkg::ADDR_W-1:0]   payload_address,
	// result
	output logic                          done,
	output logic [1:0]                    status,
	output logic                          result_present,
	output logic [ffsa_pkg::ADDR_W-1:0]   result_address,
	output logic [ffsa_pkg::SIZE_W-1:0]   granted_size,
	output logic                          copy_needed,
	output logic [ffsa_pkg::ADDR_W-1:0]   copy_from,
	output logic [ffsa_pkg::SIZE_W-1:0]   copy_length,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [ffsa_pkg::SIZE_W-1:0]   cfg_data
);
	import ffsa_pkg::*;

	cmd_t       cmd;
	dp_status_t stat;

	// config transfer always accepted
	assign cfg_ready = 1'b1;

	// sequencer: searches, table shifts and merges
	ffsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// segment table, heap top and result registers
	ffsa_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_type        (req_type),
		.request_size    (request_size),
		.address_present (address_present),
		.payload_address (payload_address),
		.cfg_we          (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.status          (status),
		.result_present  (result_present),
		.result_address  (result_address),
		.granted_size    (granted_size),
		.copy_needed     (copy_needed),
		.copy_from       (copy_from),
		.copy_length     (copy_length)
	);

endmodule
